// ===== rtl/lav_pkg.sv =====
// Shared types, row codes and rounding helper for the look-at view matrix block.
package lav_pkg;

    localparam logic [1:0] ROW_SIDE = 2'd0;
    localparam logic [1:0] ROW_UP   = 2'd1;
    localparam logic [1:0] ROW_LAST = 2'd2;

    localparam int COORD_W = 32;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
    } lav_in_t;

    typedef struct packed {
        logic        [1:0]  row_index;
        logic signed [31:0] col_zero;
        logic signed [31:0] col_one;
        logic signed [31:0] col_two;
        logic signed [31:0] translation;
        logic               last_row;
        logic               degenerate;
    } lav_out_t;

    typedef struct packed {
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
        logic signed [31:0] t;
    } lav_row_t;

    typedef struct packed {
        lav_row_t r0;
        lav_row_t r1;
        lav_row_t r2;
        logic     degen;
    } lav_mat_t;

    // shift right by 30, round half away from zero, saturate to 32 bits
    function automatic logic signed [31:0] lav_round_sat(input logic signed [67:0] v);
        logic        [67:0] mag;
        logic        [67:0] m;
        logic signed [31:0] r;
        mag = v[67] ? $unsigned(-v) : $unsigned(v);
        m   = (mag + (68'd1 << 29)) >> 30;
        if (!v[67])
        begin
            r = (m > 68'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
        end
        else
        begin
            r = (m > 68'h8000_0000) ? 32'sh8000_0000 : $signed(~m[31:0] + 32'd1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/lav_norm.sv =====
// Pipelined vector normalizer: scale, sum of squares, square root, three dividers.
module lav_norm #(
    parameter int IW   = 33,
    parameter int SB_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [IW-1:0] v [3],
    input  logic [SB_W-1:0]      in_sb,
    output logic                 out_valid,
    output logic signed [31:0]   o [3],
    output logic                 out_ok,
    output logic [SB_W-1:0]      out_sb
);
    localparam int SH_W  = $clog2(IW + 1);
    localparam int SQ_N  = 32;
    localparam int DIV_N = 31;
    localparam int LAT   = 5 + SQ_N + DIV_N + 1;
    localparam int LW    = SB_W + 4;

    logic [LAT-1:0] vld_reg;
    logic [LW-1:0]  side_reg [LAT];

    logic [IW-1:0]   m_abs [3];
    logic [IW-1:0]   mx;
    logic [IW-1:0]   m1_reg [3];
    logic [IW-1:0]   mx1_reg;
    logic [SH_W-1:0] bl;
    logic [IW-1:0]   m2_reg [3];
    logic [SH_W-1:0] bl2_reg;
    logic [30:0]     mn3_reg [3];
    logic [61:0]     sq4_reg [3];
    logic [30:0]     mn4_reg [3];
    logic [63:0]     sum5_reg;
    logic [30:0]     mn5_reg [3];

    logic [63:0] sr_rem  [1:SQ_N];
    logic [31:0] sr_root [1:SQ_N];
    logic [30:0] sr_mn   [1:SQ_N][3];

    logic [62:0] dv_rem [1:DIV_N][3];
    logic [30:0] dv_q   [1:DIV_N][3];
    logic [31:0] dv_len [1:DIV_N];

    logic signed [31:0] o_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_abs[i] = v[i][IW-1] ? $unsigned(-v[i]) : $unsigned(v[i]);
        end
        mx = m_abs[0];
        if (m_abs[1] > mx)
        begin
            mx = m_abs[1];
        end
        if (m_abs[2] > mx)
        begin
            mx = m_abs[2];
        end
    end

    always_comb
    begin
        bl = '0;
        for (int b = 0; b < IW; b++)
        begin
            if (mx1_reg[b])
            begin
                bl = SH_W'(b + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= {(mx != '0), v[2][IW-1], v[1][IW-1], v[0][IW-1], in_sb};
            for (int k = 1; k < LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            m1_reg  <= m_abs;
            mx1_reg <= mx;
            m2_reg  <= m1_reg;
            bl2_reg <= bl;
            for (int i = 0; i < 3; i++)
            begin
                if (bl2_reg > SH_W'(31))
                begin
                    mn3_reg[i] <= 31'(m2_reg[i] >> (bl2_reg - SH_W'(31)));
                end
                else
                begin
                    mn3_reg[i] <= 31'({31'd0, m2_reg[i]} << (SH_W'(31) - bl2_reg));
                end
                sq4_reg[i] <= mn3_reg[i] * mn3_reg[i];
            end
            mn4_reg  <= mn3_reg;
            sum5_reg <= 64'(sq4_reg[0]) + 64'(sq4_reg[1]) + 64'(sq4_reg[2]);
            mn5_reg  <= mn4_reg;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQ_N; k++)
    begin : g_sqrt
        localparam int I = SQ_N - 1 - k;
        logic [63:0] rem_in;
        logic [31:0] root_in;
        logic [30:0] mn_in [3];
        logic [65:0] trial;
        if (k == 0)
        begin : g_first
            assign rem_in  = sum5_reg;
            assign root_in = '0;
            assign mn_in   = mn5_reg;
        end
        else
        begin : g_next
            assign rem_in  = sr_rem[k];
            assign root_in = sr_root[k];
            assign mn_in   = sr_mn[k];
        end
        assign trial = ({34'd0, root_in} << (I + 1)) + (66'd1 << (2 * I));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ({2'b00, rem_in} >= trial)
                begin
                    sr_rem[k+1]  <= 64'({2'b00, rem_in} - trial);
                    sr_root[k+1] <= root_in | (32'd1 << I);
                end
                else
                begin
                    sr_rem[k+1]  <= rem_in;
                    sr_root[k+1] <= root_in;
                end
                sr_mn[k+1] <= mn_in;
            end
        end
    end

    // restoring division, one quotient bit per stage, three lanes
    for (genvar j = 0; j < DIV_N; j++)
    begin : g_div
        localparam int B = DIV_N - 1 - j;
        logic [62:0] rem_in [3];
        logic [30:0] q_in [3];
        logic [31:0] len_in;
        logic [62:0] dvs;
        if (j == 0)
        begin : g_first
            assign len_in = sr_root[SQ_N];
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_in[i] = {2'b00, sr_mn[SQ_N][i], 30'd0};
                assign q_in[i]   = '0;
            end
        end
        else
        begin : g_next
            assign len_in = dv_len[j];
            assign rem_in = dv_rem[j];
            assign q_in   = dv_q[j];
        end
        assign dvs = {31'd0, len_in} << B;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_in[i] >= dvs)
                    begin
                        dv_rem[j+1][i] <= rem_in[i] - dvs;
                        dv_q[j+1][i]   <= q_in[i] | (31'd1 << B);
                    end
                    else
                    begin
                        dv_rem[j+1][i] <= rem_in[i];
                        dv_q[j+1][i]   <= q_in[i];
                    end
                end
                dv_len[j+1] <= len_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                o_reg[i] <= side_reg[LAT-2][SB_W+i] ? -$signed({1'b0, dv_q[DIV_N][i]})
                                                    : $signed({1'b0, dv_q[DIV_N][i]});
            end
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign o         = o_reg;
    assign out_ok    = side_reg[LAT-1][SB_W+3];
    assign out_sb    = side_reg[LAT-1][SB_W-1:0];

endmodule

// ===== rtl/lav_cross.sv =====
// Cross product of the forward unit vector with the up vector, two stages.
module lav_cross #(
    parameter int SB_W = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] f [3],
    input  logic signed [31:0] up [3],
    input  logic [SB_W-1:0]    in_sb,
    output logic               out_valid,
    output logic signed [63:0] c [3],
    output logic [SB_W-1:0]    out_sb
);
    logic [1:0]         vld_reg;
    logic signed [63:0] p_reg [6];
    logic signed [63:0] c_reg [3];
    logic [SB_W-1:0]    sb1_reg;
    logic [SB_W-1:0]    sb2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= f[1] * up[2];
            p_reg[1] <= f[2] * up[1];
            p_reg[2] <= f[2] * up[0];
            p_reg[3] <= f[0] * up[2];
            p_reg[4] <= f[0] * up[1];
            p_reg[5] <= f[1] * up[0];
            sb1_reg  <= in_sb;
            c_reg[0] <= p_reg[0] - p_reg[1];
            c_reg[1] <= p_reg[2] - p_reg[3];
            c_reg[2] <= p_reg[4] - p_reg[5];
            sb2_reg  <= sb1_reg;
        end
    end

    assign out_valid = vld_reg[1];
    assign c         = c_reg;
    assign out_sb    = sb2_reg;

endmodule

// ===== rtl/lav_rows.sv =====
// Up vector and the three translations, four stages, packed into one matrix word.
module lav_rows (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] s [3],
    input  logic signed [31:0] f [3],
    input  logic signed [31:0] eye [3],
    input  logic               ok,
    output logic               out_valid,
    output lav_pkg::lav_mat_t  mat
);
    import lav_pkg::*;

    logic [3:0] vld_reg;

    logic signed [63:0] psf1_reg [6];
    logic signed [63:0] pse1_reg [3];
    logic signed [63:0] pfe1_reg [3];
    logic signed [31:0] s1_reg [3];
    logic signed [31:0] f1_reg [3];
    logic signed [31:0] eye1_reg [3];
    logic               ok1_reg;

    logic signed [31:0] u2_reg [3];
    logic signed [65:0] ds2_reg;
    logic signed [65:0] df2_reg;
    logic signed [31:0] s2_reg [3];
    logic signed [31:0] f2_reg [3];
    logic signed [31:0] eye2_reg [3];
    logic               ok2_reg;

    logic signed [63:0] pue3_reg [3];
    logic signed [31:0] ts3_reg;
    logic signed [31:0] tf3_reg;
    logic signed [31:0] s3_reg [3];
    logic signed [31:0] u3_reg [3];
    logic signed [31:0] f3_reg [3];
    logic               ok3_reg;

    lav_mat_t mat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            psf1_reg[0] <= s[1] * f[2];
            psf1_reg[1] <= s[2] * f[1];
            psf1_reg[2] <= s[2] * f[0];
            psf1_reg[3] <= s[0] * f[2];
            psf1_reg[4] <= s[0] * f[1];
            psf1_reg[5] <= s[1] * f[0];
            for (int i = 0; i < 3; i++)
            begin
                pse1_reg[i] <= s[i] * eye[i];
                pfe1_reg[i] <= f[i] * eye[i];
            end
            s1_reg   <= s;
            f1_reg   <= f;
            eye1_reg <= eye;
            ok1_reg  <= ok;

            for (int i = 0; i < 3; i++)
            begin
                u2_reg[i] <= lav_round_sat(68'(psf1_reg[2*i]) - 68'(psf1_reg[2*i+1]));
            end
            ds2_reg  <= 66'(pse1_reg[0]) + 66'(pse1_reg[1]) + 66'(pse1_reg[2]);
            df2_reg  <= 66'(pfe1_reg[0]) + 66'(pfe1_reg[1]) + 66'(pfe1_reg[2]);
            s2_reg   <= s1_reg;
            f2_reg   <= f1_reg;
            eye2_reg <= eye1_reg;
            ok2_reg  <= ok1_reg;

            for (int i = 0; i < 3; i++)
            begin
                pue3_reg[i] <= u2_reg[i] * eye2_reg[i];
            end
            ts3_reg <= lav_round_sat(-68'(ds2_reg));
            tf3_reg <= lav_round_sat(68'(df2_reg));
            s3_reg  <= s2_reg;
            u3_reg  <= u2_reg;
            f3_reg  <= f2_reg;
            ok3_reg <= ok2_reg;

            mat_reg.r0.c0 <= s3_reg[0];
            mat_reg.r0.c1 <= s3_reg[1];
            mat_reg.r0.c2 <= s3_reg[2];
            mat_reg.r0.t  <= ts3_reg;
            mat_reg.r1.c0 <= u3_reg[0];
            mat_reg.r1.c1 <= u3_reg[1];
            mat_reg.r1.c2 <= u3_reg[2];
            mat_reg.r1.t  <= lav_round_sat(-(68'(pue3_reg[0]) + 68'(pue3_reg[1])
                                             + 68'(pue3_reg[2])));
            mat_reg.r2.c0 <= -f3_reg[0];
            mat_reg.r2.c1 <= -f3_reg[1];
            mat_reg.r2.c2 <= -f3_reg[2];
            mat_reg.r2.t  <= tf3_reg;
            mat_reg.degen <= !ok3_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign mat       = mat_reg;

endmodule

// ===== rtl/lav_out.sv =====
// Output stage: holds one matrix and sends its three rows, drives the pipeline advance.
module lav_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  lav_pkg::lav_mat_t in_mat,
    output logic              en,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output lav_pkg::lav_out_t rsp
);
    import lav_pkg::*;

    logic       full_reg;
    logic [1:0] row_reg;
    lav_mat_t   mat_reg;
    lav_mat_t   mat_load;
    lav_row_t   row_sel;

    assign en = !full_reg || (rsp_ready && row_reg == ROW_LAST);

    always_comb
    begin
        mat_load = in_mat;
        if (in_mat.degen)
        begin
            mat_load       = '0;
            mat_load.degen = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            row_reg  <= ROW_SIDE;
        end
        else if (en)
        begin
            full_reg <= in_valid;
            row_reg  <= ROW_SIDE;
        end
        else if (rsp_ready)
        begin
            row_reg <= row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            mat_reg <= mat_load;
        end
    end

    always_comb
    begin
        case (row_reg)
            ROW_SIDE: row_sel = mat_reg.r0;
            ROW_UP:   row_sel = mat_reg.r1;
            ROW_LAST: row_sel = mat_reg.r2;
            default:  row_sel = '0;
        endcase
    end

    assign rsp_valid           = full_reg;
    assign rsp.row_index       = row_reg;
    assign rsp.col_zero        = row_sel.c0;
    assign rsp.col_one         = row_sel.c1;
    assign rsp.col_two         = row_sel.c2;
    assign rsp.translation     = row_sel.t;
    assign rsp.last_row        = (row_reg == ROW_LAST);
    assign rsp.degenerate      = mat_reg.degen;

    a_load_starts_side: assert property (@(posedge clk) disable iff (!rst_n)
        (en && in_valid) |=> (full_reg && row_reg == ROW_SIDE))
        else $error("new matrix did not start at the side row");

    a_row_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg && rsp_ready && row_reg != ROW_LAST)
            |=> (full_reg && row_reg == $past(row_reg) + 2'd1))
        else $error("row index did not advance");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.degenerate) |-> (rsp.col_zero == 0 && rsp.col_one == 0
            && rsp.col_two == 0 && rsp.translation == 0))
        else $error("degenerate row carries nonzero entries");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (row_reg == ROW_SIDE || row_reg == ROW_UP || row_reg == ROW_LAST))
        else $error("row index out of range");

endmodule

// ===== rtl/look_at_view_matrix.sv =====
// Look-at view matrix builder, top level.
//
// Input channel req/req_valid/req_ready takes one word: eye, target and up
// vectors, signed Q16.16. Output channel rsp/rsp_valid/rsp_ready gives three
// words per input, rows 0 (side), 1 (up), 2 (negated forward); rotation
// entries are Q2.30, translation Q16.16 saturated; last_row marks row 2 and
// degenerate flags a zero-length forward or side vector (rows then zero).
// After acceptance, the first row is sent once the matrix reaches the output
// stage; the other two rows follow on the next cycles when rsp_ready is high.
// The output stage sends one row per cycle while rsp_ready is high; the
// 145 stage pipeline (two normalizers, each with a 32 stage square root
// and 31 stage dividers) advances only when the output stage can take a
// new matrix; new inputs enter while earlier ones are still in flight.
// Reset clears all valid bits and the output stage; no item is in flight.
// When the receiver stalls, the whole pipeline holds and req_ready drops.
module look_at_view_matrix (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  lav_pkg::lav_in_t req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output lav_pkg::lav_out_t rsp
);
    import lav_pkg::*;

    localparam int D_W   = COORD_W + 1;
    localparam int C_W   = 2 * COORD_W;
    localparam int SB1_W = 6 * COORD_W;
    localparam int SB2_W = 6 * COORD_W + 1;

    logic en;

    logic               vld0_reg;
    logic signed [D_W-1:0]     d0_reg [3];
    logic signed [COORD_W-1:0] eye0_reg [3];
    logic signed [COORD_W-1:0] up0_reg [3];

    logic               n1_valid;
    logic signed [31:0] f1 [3];
    logic               ok1;
    logic [SB1_W-1:0]   sb1;
    logic signed [31:0] eye1 [3];
    logic signed [31:0] up1 [3];

    logic               x_valid;
    logic signed [C_W-1:0] c2 [3];
    logic [SB2_W-1:0]   sb2;

    logic               n2_valid;
    logic signed [31:0] s3 [3];
    logic               ok2;
    logic [SB2_W-1:0]   sb3;
    logic signed [31:0] f3 [3];
    logic signed [31:0] eye3 [3];

    logic     r_valid;
    lav_mat_t r_mat;

    assign req_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_reg[0]   <= D_W'(req.target_x) - D_W'(req.eye_x);
            d0_reg[1]   <= D_W'(req.target_y) - D_W'(req.eye_y);
            d0_reg[2]   <= D_W'(req.target_z) - D_W'(req.eye_z);
            eye0_reg[0] <= req.eye_x;
            eye0_reg[1] <= req.eye_y;
            eye0_reg[2] <= req.eye_z;
            up0_reg[0]  <= req.up_x;
            up0_reg[1]  <= req.up_y;
            up0_reg[2]  <= req.up_z;
        end
    end

    lav_norm #(
        .IW   (D_W),
        .SB_W (SB1_W)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld0_reg),
        .v         (d0_reg),
        .in_sb     ({eye0_reg[0], eye0_reg[1], eye0_reg[2],
                     up0_reg[0], up0_reg[1], up0_reg[2]}),
        .out_valid (n1_valid),
        .o         (f1),
        .out_ok    (ok1),
        .out_sb    (sb1)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye1[i] = $signed(sb1[SB1_W-1-COORD_W*i -: COORD_W]);
            up1[i]  = $signed(sb1[3*COORD_W-1-COORD_W*i -: COORD_W]);
        end
    end

    lav_cross #(
        .SB_W (SB2_W)
    ) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n1_valid),
        .f         (f1),
        .up        (up1),
        .in_sb     ({ok1, f1[0], f1[1], f1[2], eye1[0], eye1[1], eye1[2]}),
        .out_valid (x_valid),
        .c         (c2),
        .out_sb    (sb2)
    );

    lav_norm #(
        .IW   (C_W),
        .SB_W (SB2_W)
    ) u_norm_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (x_valid),
        .v         (c2),
        .in_sb     (sb2),
        .out_valid (n2_valid),
        .o         (s3),
        .out_ok    (ok2),
        .out_sb    (sb3)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            f3[i]   = $signed(sb3[SB2_W-2-COORD_W*i -: COORD_W]);
            eye3[i] = $signed(sb3[3*COORD_W-1-COORD_W*i -: COORD_W]);
        end
    end

    lav_rows u_rows (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n2_valid),
        .s         (s3),
        .f         (f3),
        .eye       (eye3),
        .ok        (sb3[SB2_W-1] & ok2),
        .out_valid (r_valid),
        .mat       (r_mat)
    );

    lav_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_mat    (r_mat),
        .en        (en),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== tb/tb.sv =====
// Testbench for the look-at view matrix builder: directed and random views checked row by row.
`timescale 1ns / 100ps

module tb;
    import lav_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    lav_in_t  req;
    logic     rsp_valid;
    logic     rsp_ready;
    lav_out_t rsp;

    lav_out_t row_queue[$];
    int       errors;
    int       rows_seen;
    int       views_sent;
    bit       hold_rsp;
    bit       gaps_on;

    look_at_view_matrix i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("look_at_view_matrix: mismatch");
        $finish;
    end

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [63:0] round30(input logic signed [63:0] v);
        logic [63:0] m;
        m = (abs64(v) + (64'd1 << 29)) >> 30;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit unit_vec(input logic signed [63:0] v[3],
                                    output logic signed [63:0] o[3]);
        logic [63:0] m[3];
        logic [63:0] mx;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = abs64(v[i]);
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
            return 0;
        while (mx >= (64'd1 << 31))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 30))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++)
            sum = sum + m[i] * m[i];
        len = root64(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = (m[i] << 30) / len;
            o[i] = v[i][63] ? -$signed(q) : $signed(q);
        end
        return 1;
    endfunction

    task automatic predict_rows(input lav_in_t w);
        logic signed [63:0] eye[3];
        logic signed [63:0] up[3];
        logic signed [63:0] d[3];
        logic signed [63:0] f[3];
        logic signed [63:0] c[3];
        logic signed [63:0] s[3];
        logic signed [63:0] u[3];
        logic signed [63:0] mat[3][4];
        logic signed [63:0] ds;
        logic signed [63:0] du;
        logic signed [63:0] df;
        lav_out_t o;
        bit degen;
        eye[0] = w.eye_x; eye[1] = w.eye_y; eye[2] = w.eye_z;
        up[0] = w.up_x; up[1] = w.up_y; up[2] = w.up_z;
        d[0] = 64'(w.target_x) - eye[0];
        d[1] = 64'(w.target_y) - eye[1];
        d[2] = 64'(w.target_z) - eye[2];
        foreach (mat[r, i])
            mat[r][i] = 0;
        degen = 0;
        if (!unit_vec(d, f))
            degen = 1;
        else
        begin
            c[0] = f[1] * up[2] - f[2] * up[1];
            c[1] = f[2] * up[0] - f[0] * up[2];
            c[2] = f[0] * up[1] - f[1] * up[0];
            if (!unit_vec(c, s))
                degen = 1;
            else
            begin
                u[0] = clip32(round30(s[1] * f[2] - s[2] * f[1]));
                u[1] = clip32(round30(s[2] * f[0] - s[0] * f[2]));
                u[2] = clip32(round30(s[0] * f[1] - s[1] * f[0]));
                ds = 0; du = 0; df = 0;
                for (int i = 0; i < 3; i++)
                begin
                    mat[0][i] = s[i];
                    mat[1][i] = u[i];
                    mat[2][i] = -f[i];
                    ds = ds + s[i] * eye[i];
                    du = du + u[i] * eye[i];
                    df = df + f[i] * eye[i];
                end
                mat[0][3] = clip32(round30(-ds));
                mat[1][3] = clip32(round30(-du));
                mat[2][3] = clip32(round30(df));
            end
        end
        for (int r = 0; r < 3; r++)
        begin
            o.row_index   = 2'(r);
            o.col_zero    = mat[r][0][31:0];
            o.col_one     = mat[r][1][31:0];
            o.col_two     = mat[r][2][31:0];
            o.translation = mat[r][3][31:0];
            o.last_row    = (2'(r) == ROW_LAST);
            o.degenerate  = degen;
            row_queue.push_back(o);
        end
    endtask

    task automatic send_view(input lav_in_t w);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        predict_rows(w);
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        views_sent++;
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_rsp)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(0, 9) < 7) || !gaps_on;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rows_seen++;
            if (row_queue.size() == 0)
            begin
                errors++;
                $display("%0t unexpected row: actual %p", $time, rsp);
            end
            else
            begin
                lav_out_t e;
                e = row_queue.pop_front();
                if (rsp !== e)
                begin
                    errors++;
                    $display("%0t row mismatch: expected %p actual %p", $time, e, rsp);
                end
            end
        end
    end

    function automatic lav_in_t rand_view();
        lav_in_t w;
        int k;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
        k = $urandom_range(0, 9);
        if (k < 5)
        begin
            // modest coordinates, typical scenes
            w.eye_x = $signed($urandom) >>> $urandom_range(4, 16);
            w.eye_y = $signed($urandom) >>> $urandom_range(4, 16);
            w.eye_z = $signed($urandom) >>> $urandom_range(4, 16);
            w.target_x = $signed($urandom) >>> $urandom_range(4, 16);
            w.target_y = $signed($urandom) >>> $urandom_range(4, 16);
            w.target_z = $signed($urandom) >>> $urandom_range(4, 16);
            w.up_x = $signed($urandom) >>> $urandom_range(8, 20);
            w.up_y = $signed($urandom) >>> $urandom_range(0, 20);
            w.up_z = $signed($urandom) >>> $urandom_range(8, 20);
        end
        else if (k == 5)
        begin
            w.target_x = w.eye_x; w.target_y = w.eye_y; w.target_z = w.eye_z;
        end
        else if (k == 6)
        begin
            w.up_x = w.target_x - w.eye_x;
            w.up_y = w.target_y - w.eye_y;
            w.up_z = w.target_z - w.eye_z;
            w.eye_x = w.eye_x >>> 2; w.eye_y = w.eye_y >>> 2; w.eye_z = w.eye_z >>> 2;
            w.target_x = w.eye_x + (w.up_x >>> 2);
            w.target_y = w.eye_y + (w.up_y >>> 2);
            w.target_z = w.eye_z + (w.up_z >>> 2);
            w.up_x = w.up_x >>> 2; w.up_y = w.up_y >>> 2; w.up_z = w.up_z >>> 2;
        end
        else if (k == 7)
        begin
            w.up_x = 0; w.up_y = 0; w.up_z = 0;
        end
        return w;
    endfunction

    task automatic drain();
        int n;
        n = 0;
        req_valid <= 1'b0;
        while (row_queue.size() != 0 && n < 200000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (160) @(posedge clk);
    endtask

    task automatic test_directed();
        lav_in_t w;
        logic signed [31:0] ext[4];
        ext[0] = 32'sh7FFF_FFFF; ext[1] = 32'sh8000_0000; ext[2] = 0; ext[3] = 32'sh0001_0000;
        w = '0; w.target_z = -32'sh0001_0000; w.up_y = 32'sh0001_0000;
        send_view(w);
        w = '0; w.up_y = 32'sh0001_0000;
        send_view(w);
        w = '0; w.target_z = 32'sh0001_0000;
        send_view(w);
        w = '0; w.target_y = 32'sh0001_0000; w.up_y = 32'sh0005_0000;
        send_view(w);
        w = '0; w.eye_x = 32'sh8000_0000; w.eye_y = 32'sh8000_0000; w.eye_z = 32'sh8000_0000;
        w.target_x = 32'sh7FFF_FFFF; w.target_y = 32'sh7FFF_FFFF;
        w.target_z = 32'sh8000_0000;
        w.up_x = 32'sh7FFF_FFFF; w.up_y = 32'sh8000_0000; w.up_z = 32'sh7FFF_FFFF;
        send_view(w);
        w = {9{32'hFFFF_FFFF}}; w.target_x = 32'sh7FFF_FFFF;
        send_view(w);
        w.eye_x = 32'sh7FFF_FFFF; w.eye_y = 32'sh7FFF_FFFF; w.eye_z = 32'sh7FFF_FFFF;
        w.target_x = 32'sh8000_0000; w.target_y = 32'sh8000_0000; w.target_z = 32'sh7FFF_FFFF;
        w.up_x = 32'sh8000_0000; w.up_y = 32'sh7FFF_FFFF; w.up_z = 1;
        send_view(w);
        for (int i = 0; i < 12; i++)
        begin
            w.eye_x = ext[$urandom_range(0, 3)]; w.eye_y = ext[$urandom_range(0, 3)];
            w.eye_z = ext[$urandom_range(0, 3)];
            w.target_x = ext[$urandom_range(0, 3)]; w.target_y = ext[$urandom_range(0, 3)];
            w.target_z = ext[$urandom_range(0, 3)];
            w.up_x = ext[$urandom_range(0, 3)]; w.up_y = ext[$urandom_range(0, 3)];
            w.up_z = ext[$urandom_range(0, 3)];
            send_view(w);
        end
        w = '0; w.target_x = 1; w.up_z = 1;
        send_view(w);
        drain();
    endtask

    task automatic test_random();
        gaps_on = 1;
        for (int i = 0; i < 80; i++)
            send_view(rand_view());
        drain();
    endtask

    task automatic test_backpressure();
        gaps_on = 0;
        fork
            begin
                hold_rsp = 1;
                repeat (600) @(posedge clk);
                hold_rsp = 0;
            end
            for (int i = 0; i < 160; i++)
                send_view(rand_view());
        join
        gaps_on = 1;
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        errors = 0;
        rows_seen = 0;
        views_sent = 0;
        hold_rsp = 0;
        gaps_on = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        if (row_queue.size() != 0)
        begin
            errors++;
            $display("%0t %0d rows never arrived", $time, row_queue.size());
        end
        $display("covered %0d views, %0d rows: extremes, degenerate, random, stalls",
                 views_sent, rows_seen);
        if (errors == 0)
            $display("look_at_view_matrix: match");
        else
            $display("look_at_view_matrix: mismatch");
        $finish;
    end
endmodule
